/* hdl/csqs_pkg.sv */
// shared types, constants and weight table for the closed quadratic spline sampler
// no dependencies
package csqs_pkg;

  localparam int CoordBits     = 16;
  localparam int WeightBits    = 6;
  localparam int SamplesPerSeg = 5;
  localparam int SampleIdxBits = 3;

  localparam logic [SampleIdxBits-1:0] LastSample = SampleIdxBits'(SamplesPerSeg - 1);

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic                        final_point;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] curve_x;
    logic signed [CoordBits-1:0] curve_y;
    logic                        loop_done;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } point_t;

  typedef struct packed {
    point_t a;
    point_t b;
    point_t c;
    logic   last;
  } seg_t;

  typedef struct packed {
    logic [WeightBits-1:0] wa;
    logic [WeightBits-1:0] wb;
    logic [WeightBits-1:0] wc;
  } weights_t;

  // blend weights in fiftieths for each sample of a segment
  function automatic weights_t sample_weights(input logic [SampleIdxBits-1:0] idx);
    weights_t w;
    case (idx)
      3'd0:    w = '{wa: 6'd25, wb: 6'd25, wc: 6'd0};
      3'd1:    w = '{wa: 6'd16, wb: 6'd33, wc: 6'd1};
      3'd2:    w = '{wa: 6'd9,  wb: 6'd37, wc: 6'd4};
      3'd3:    w = '{wa: 6'd4,  wb: 6'd37, wc: 6'd9};
      3'd4:    w = '{wa: 6'd1,  wb: 6'd33, wc: 6'd16};
      default: w = '{wa: 6'd25, wb: 6'd25, wc: 6'd0};
    endcase
    return w;
  endfunction

endpackage

/* hdl/csqs_front.sv */
// front end: takes control points, tracks loop state, queues up segment jobs
// depends on csqs_pkg
module csqs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csqs_pkg::in_word_t in_word_i,
  output logic              push_o,
  output csqs_pkg::seg_t    push_seg_o,
  input  logic              full_i
);

  csqs_pkg::point_t first_q, first_d;
  csqs_pkg::point_t second_q, second_d;
  csqs_pkg::point_t older_q, older_d;
  csqs_pkg::point_t newer_q, newer_d;
  logic [1:0]       seen_q, seen_d;
  csqs_pkg::seg_t   segs_q [3];
  csqs_pkg::seg_t   segs_d [3];
  logic [1:0]       pend_q, pend_d;

  csqs_pkg::point_t p;
  csqs_pkg::point_t first_n;
  csqs_pkg::point_t second_n;
  csqs_pkg::seg_t   mid_seg, wrap1_seg, wrap2_seg, solo_seg;
  logic             accept;

  assign in_stall_o = (pend_q != 2'd0);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = (pend_q != 2'd0);
  assign push_seg_o = segs_q[0];

  assign p        = '{x: in_word_i.point_x, y: in_word_i.point_y};
  assign first_n  = (seen_q == 2'd0) ? p : first_q;
  assign second_n = (seen_q == 2'd1) ? p : second_q;

  assign mid_seg   = '{a: older_q, b: newer_q, c: p, last: 1'b0};
  assign wrap1_seg = '{a: newer_q, b: p, c: first_n, last: 1'b0};
  assign wrap2_seg = '{a: p, b: first_n, c: second_n, last: 1'b1};
  assign solo_seg  = '{a: p, b: p, c: p, last: 1'b1};

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    older_d  = older_q;
    newer_d  = newer_q;
    seen_d   = seen_q;
    segs_d   = segs_q;
    pend_d   = pend_q;

    if (push_o && !full_i) begin
      segs_d[0] = segs_q[1];
      segs_d[1] = segs_q[2];
      pend_d    = pend_q - 2'd1;
    end

    if (accept) begin
      if (seen_q >= 2'd2) begin
        segs_d[0] = mid_seg;
        if (in_word_i.final_point) begin
          segs_d[1] = wrap1_seg;
          segs_d[2] = wrap2_seg;
          pend_d    = 2'd3;
        end else begin
          pend_d = 2'd1;
        end
      end else if (in_word_i.final_point) begin
        if (seen_q == 2'd0) begin
          segs_d[0] = solo_seg;
          pend_d    = 2'd1;
        end else begin
          segs_d[0] = wrap1_seg;
          segs_d[1] = wrap2_seg;
          pend_d    = 2'd2;
        end
      end

      if (in_word_i.final_point) begin
        first_d  = '0;
        second_d = '0;
        older_d  = '0;
        newer_d  = '0;
        seen_d   = 2'd0;
      end else begin
        first_d  = first_n;
        second_d = second_n;
        older_d  = newer_q;
        newer_d  = p;
        seen_d   = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      older_q  <= '0;
      newer_q  <= '0;
      seen_q   <= 2'd0;
      pend_q   <= 2'd0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      older_q  <= older_d;
      newer_q  <= newer_d;
      seen_q   <= seen_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    segs_q <= segs_d;
  end

endmodule

/* hdl/csqs_fifo.sv */
// small register queue of segment jobs between front and back
// depends on csqs_pkg
module csqs_fifo #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  csqs_pkg::seg_t push_seg_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output csqs_pkg::seg_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  csqs_pkg::seg_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_seg_i;
    end
  end

endmodule

/* hdl/csqs_back.sv */
// back end: steps through the five samples of each queued segment and runs
// the blend and divide-by-fifty pipeline; depends on csqs_pkg
module csqs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seg_valid_i,
  input  csqs_pkg::seg_t      seg_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csqs_pkg::out_word_t out_word_o
);

  localparam int Cb    = csqs_pkg::CoordBits;
  localparam int W     = Cb + 6;
  localparam int Mw    = Cb + 1;
  localparam int L     = W / 2;
  localparam int H     = W - L;
  localparam int Lanes = 2;

  localparam logic [Mw-1:0]       Recip = Mw'((64'd1 << W) / 64'd50);
  localparam logic signed [W:0]   Bias  = (W + 1)'(25) + ((W + 1)'(25) << Cb);
  localparam logic [W-1:0]        Fifty = W'(50);

  logic [csqs_pkg::SampleIdxBits-1:0] idx_q, idx_d;
  logic                               en, issue;
  csqs_pkg::weights_t                 wts;

  logic v1_q, v2_q, v3_q, out_valid_q;
  logic done1_q, done2_q, done3_q;
  logic [Cb-1:0] res [Lanes];
  csqs_pkg::out_word_t out_word_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign issue       = seg_valid_i && en;
  assign pop_o       = issue && (idx_q == csqs_pkg::LastSample);
  assign wts         = csqs_pkg::sample_weights(idx_q);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    idx_d = idx_q;
    if (issue) begin
      idx_d = (idx_q == csqs_pkg::LastSample) ? '0
            : idx_q + csqs_pkg::SampleIdxBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (en) begin
        v1_q        <= issue;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        out_valid_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      done1_q              <= seg_i.last && (idx_q == csqs_pkg::LastSample);
      done2_q              <= done1_q;
      done3_q              <= done2_q;
      out_word_q.curve_x   <= res[0];
      out_word_q.curve_y   <= res[1];
      out_word_q.loop_done <= done3_q;
    end
  end

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    logic signed [Cb-1:0] ca, cb, cc;
    logic signed [W:0]    acc;
    logic [W-1:0]         x1_q, x2_q, x3_q;
    logic [L+Mw-1:0]      pl_q;
    logic [H+Mw-1:0]      ph_q;
    logic [W+Mw-1:0]      prod;
    logic [Mw-1:0]        qe_q;
    logic [W-1:0]         times50;
    logic [W-1:0]         rem;
    logic [Mw-1:0]        quo;

    assign ca = (g == 0) ? seg_i.a.x : seg_i.a.y;
    assign cb = (g == 0) ? seg_i.b.x : seg_i.b.y;
    assign cc = (g == 0) ? seg_i.c.x : seg_i.c.y;

    // weighted sum, biased to stay non-negative
    assign acc = (W + 1)'(ca) * $signed({1'b0, wts.wa})
               + (W + 1)'(cb) * $signed({1'b0, wts.wb})
               + (W + 1)'(cc) * $signed({1'b0, wts.wc});

    // reciprocal estimate is floor(x/50) or one below it
    assign prod    = ((W + Mw)'(ph_q) << L) + (W + Mw)'(pl_q);
    assign times50 = (W'(qe_q) << 5) + (W'(qe_q) << 4) + (W'(qe_q) << 1);
    assign rem     = x3_q - times50;
    assign quo     = qe_q + Mw'(rem >= Fifty);
    assign res[g]  = {~quo[Cb-1], quo[Cb-2:0]};

    always_ff @(posedge clk_i) begin
      if (en) begin
        x1_q <= W'(acc + Bias);
        pl_q <= (L + Mw)'(x1_q[L-1:0]) * (L + Mw)'(Recip);
        ph_q <= (H + Mw)'(x1_q[W-1:L]) * (H + Mw)'(Recip);
        x2_q <= x1_q;
        qe_q <= prod[W+Mw-1:W];
        x3_q <= x2_q;
      end
    end
  end

endmodule

/* hdl/closed_quadratic_spline_sampler_core.sv */
// top level of the closed quadratic spline sampler: front end, segment queue, back end
// depends on csqs_pkg, csqs_front, csqs_fifo, csqs_back
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o  | csqs_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i | csqs_pkg::out_word_t
//
// the back end emits one sample per cycle while not stalled, five per segment, so a point that
// closes a segment yields five samples, a final point up to fifteen, and the two opening points none
// each sample passes 3 pipeline registers plus the output register once its segment
// reaches the queue head; the front end stalls input until its segments are queued
// reset clears loop state, queue pointers and pipeline valids; out_stall_i freezes the
// back end pipeline while an output is valid, and the queue lets the front keep taking points until it fills
module closed_quadratic_spline_sampler_core #(
  parameter int QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csqs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csqs_pkg::out_word_t out_word_o
);

  logic           push, full, pop, empty;
  csqs_pkg::seg_t push_seg, head_seg;

  csqs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .push_seg_o (push_seg),
    .full_i     (full)
  );

  csqs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_seg_i (push_seg),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_seg)
  );

  csqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_valid_i (!empty),
    .seg_i       (head_seg),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
